// ===== sv/brrs_pkg.sv =====
package brrs_pkg;

    localparam int OPCODE_W  = 2;
    localparam int INDEX_W   = 10;
    localparam int ENTRY_W   = 32;
    localparam int OFFSET_W  = 40;
    localparam int COUNT_W   = 32;
    localparam int PHYS_W    = 48;
    localparam int LEN_W     = 17;
    localparam int BS_W      = 17;
    localparam int EXT_W     = 17;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

    localparam logic [BS_W-1:0] BS_RESET = 17'd16384;
    localparam logic [BS_W-1:0] BS_MIN   = 17'd1;
    localparam logic [BS_W-1:0] BS_MAX   = 17'd65536;

    localparam int DIV_BITS  = 4;
    localparam int DIV_ITERS = OFFSET_W / DIV_BITS;
    localparam int DIV_CNT_W = 4;

    typedef enum logic [1:0] {
        EMIT_PIECE,
        EMIT_ZERO,
        EMIT_ERROR
    } emit_kind_t;

    typedef struct packed {
        logic       take;
        logic       div_step;
        logic       check;
        logic       rd;
        logic       mul;
        logic       emit;
        emit_kind_t kind;
        logic       advance;
    } brrs_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] in_op;
        logic                in_count_zero;
        logic                div_done;
        logic                range_err;
        logic                final_piece;
        logic                out_free;
    } brrs_status_t;

endpackage

// ===== sv/brrs_ctrl.sv =====
module brrs_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    output brrs_pkg::brrs_cmd_t   cmd,
    input  brrs_pkg::brrs_status_t status
);
    import brrs_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_RANGE,
        ST_READ,
        ST_MUL,
        ST_EMIT
    } state_t;

    state_t     state_reg, state_next;
    emit_kind_t kind_reg, kind_next;

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        cmd.kind   = kind_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.take = 1'b1;
                    if (status.in_op == OP_READ || status.in_op == OP_WRITE) begin
                        if (status.in_count_zero) begin
                            state_next = ST_EMIT;
                            kind_next  = EMIT_ZERO;
                        end else begin
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                cmd.check  = 1'b1;
                state_next = ST_RANGE;
            end
            ST_RANGE: begin
                state_next = ST_EMIT;
                if (status.range_err) begin
                    kind_next = EMIT_ERROR;
                end else begin
                    kind_next  = EMIT_PIECE;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd     = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit    = 1'b1;
                    cmd.advance = (kind_reg == EMIT_PIECE);
                    if (kind_reg == EMIT_PIECE && !status.final_piece) begin
                        state_next = ST_READ;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= EMIT_PIECE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

endmodule

// ===== sv/brrs_datapath.sv =====
module brrs_datapath #(
    parameter int MAP_DEPTH  = 1024,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [brrs_pkg::BS_W-1:0]       cfg_wr_data,
    input  logic [brrs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic [brrs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [brrs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic [brrs_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast,
    input  brrs_pkg::brrs_cmd_t             cmd,
    output brrs_pkg::brrs_status_t          status
);
    import brrs_pkg::*;

    localparam int AW      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
    localparam int LMAP_W  = 34;
    localparam int LCHK_W  = 24;
    localparam int END_W   = OFFSET_W + 1;
    localparam int SPAN_W  = COUNT_W + 1;
    localparam int PROD_W  = ENTRY_W + BS_W;

    logic [OPCODE_W-1:0] in_op;
    logic [INDEX_W-1:0]  in_index;
    logic [ENTRY_W-1:0]  in_entry;
    logic [OFFSET_W-1:0] in_offset;
    logic [COUNT_W-1:0]  in_count;
    logic [EXT_W-1:0]    idx_ext;
    logic                idx_in_range;

    logic [ENTRY_W-1:0]  map_mem [MAP_DEPTH];
    logic [ENTRY_W-1:0]  rd_data_reg;

    logic [BS_W-1:0]     bs_reg, bs_next;
    logic [OFFSET_W-1:0] dvd_reg, dvd_next;
    logic [BS_W-1:0]     rmd_reg, rmd_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic                wr_reg, wr_next;
    logic [END_W-1:0]    endpos_reg, endpos_next;
    logic [LMAP_W-1:0]   lim_map_reg, lim_map_next;
    logic [LCHK_W-1:0]   lim_chunk_reg, lim_chunk_next;
    logic [SPAN_W-1:0]   span_reg, span_next;
    logic [AW-1:0]       blk_reg, blk_next;
    logic [BS_W-1:0]     within_reg, within_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;

    logic                out_valid_reg, out_valid_next;
    logic [PHYS_W-1:0]   out_phys_reg, out_phys_next;
    logic [LEN_W-1:0]    out_len_reg, out_len_next;
    logic                out_wr_reg, out_wr_next;
    logic                out_last_reg, out_last_next;
    logic                out_err_reg, out_err_next;

    logic [BS_W-1:0]     room;
    logic                final_piece;

    assign in_op     = s_axis_tuser[1:0];
    assign in_index  = s_axis_tdata[9:0];
    assign in_entry  = s_axis_tdata[41:10];
    assign in_offset = s_axis_tdata[81:42];
    assign in_count  = s_axis_tdata[113:82];

    assign idx_ext      = EXT_W'(in_index);
    assign idx_in_range = idx_ext < EXT_W'(MAP_DEPTH);

    always_ff @(posedge aclk) begin
        if (cmd.take && in_op == OP_LOAD && idx_in_range) begin
            map_mem[idx_ext[AW-1:0]] <= in_entry;
        end
        if (cmd.rd) begin
            rd_data_reg <= map_mem[blk_reg];
        end
    end

    assign room        = bs_reg - within_reg;
    assign final_piece = (rem_reg == COUNT_W'(len_reg));

    always_comb begin
        logic [BS_W:0]       trial;
        logic [BS_W-1:0]     r;
        logic [OFFSET_W-1:0] d;

        bs_next        = bs_reg;
        dvd_next       = dvd_reg;
        rmd_next       = rmd_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        wr_next        = wr_reg;
        endpos_next    = endpos_reg;
        lim_map_next   = lim_map_reg;
        lim_chunk_next = lim_chunk_reg;
        span_next      = span_reg;
        blk_next       = blk_reg;
        within_next    = within_reg;
        len_next       = len_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        out_phys_next  = out_phys_reg;
        out_len_next   = out_len_reg;
        out_wr_next    = out_wr_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;

        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                bs_next = BS_MIN;
            end else if (cfg_wr_data > BS_MAX) begin
                bs_next = BS_MAX;
            end else begin
                bs_next = cfg_wr_data;
            end
        end

        if (cmd.take) begin
            dvd_next     = in_offset;
            rmd_next     = '0;
            div_cnt_next = '0;
            rem_next     = in_count;
            wr_next      = (in_op == OP_WRITE);
            endpos_next  = END_W'(in_offset) + END_W'(in_count);
        end

        r = rmd_reg;
        d = dvd_reg;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial = {r, d[OFFSET_W-1]};
            d     = {d[OFFSET_W-2:0], 1'b0};
            if (trial >= {1'b0, bs_reg}) begin
                trial = trial - {1'b0, bs_reg};
                d[0]  = 1'b1;
            end
            r = trial[BS_W-1:0];
        end
        if (cmd.div_step) begin
            dvd_next     = d;
            rmd_next     = r;
            div_cnt_next = div_cnt_reg + 1'b1;
        end

        if (cmd.check) begin
            lim_map_next   = LMAP_W'(bs_reg) * LMAP_W'(MAP_DEPTH);
            lim_chunk_next = LCHK_W'(bs_reg) * LCHK_W'(MAX_CHUNKS);
            span_next      = SPAN_W'(rmd_reg) + SPAN_W'(rem_reg);
            blk_next       = dvd_reg[AW-1:0];
            within_next    = rmd_reg;
        end

        if (cmd.rd) begin
            len_next = (rem_reg < COUNT_W'(room)) ? rem_reg[LEN_W-1:0] : room;
        end

        if (cmd.mul) begin
            prod_next = PROD_W'(rd_data_reg) * PROD_W'(bs_reg);
        end

        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
            case (cmd.kind)
                EMIT_PIECE: begin
                    out_phys_next = prod_reg[PHYS_W-1:0] + PHYS_W'(within_reg);
                    out_len_next  = len_reg;
                    out_wr_next   = wr_reg;
                    out_last_next = final_piece;
                    out_err_next  = 1'b0;
                end
                EMIT_ZERO: begin
                    out_phys_next = '0;
                    out_len_next  = '0;
                    out_wr_next   = wr_reg;
                    out_last_next = 1'b1;
                    out_err_next  = 1'b0;
                end
                default: begin
                    out_phys_next = '0;
                    out_len_next  = '0;
                    out_wr_next   = 1'b0;
                    out_last_next = 1'b0;
                    out_err_next  = 1'b1;
                end
            endcase
        end

        if (cmd.advance) begin
            rem_next    = rem_reg - COUNT_W'(len_reg);
            blk_next    = blk_reg + 1'b1;
            within_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bs_reg        <= BS_RESET;
            out_valid_reg <= 1'b0;
            div_cnt_reg   <= '0;
        end else begin
            bs_reg        <= bs_next;
            out_valid_reg <= out_valid_next;
            div_cnt_reg   <= div_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg       <= dvd_next;
        rmd_reg       <= rmd_next;
        rem_reg       <= rem_next;
        wr_reg        <= wr_next;
        endpos_reg    <= endpos_next;
        lim_map_reg   <= lim_map_next;
        lim_chunk_reg <= lim_chunk_next;
        span_reg      <= span_next;
        blk_reg       <= blk_next;
        within_reg    <= within_next;
        len_reg       <= len_next;
        prod_reg      <= prod_next;
        out_phys_reg  <= out_phys_next;
        out_len_reg   <= out_len_next;
        out_wr_reg    <= out_wr_next;
        out_last_reg  <= out_last_next;
        out_err_reg   <= out_err_next;
    end

    assign status.in_op         = in_op;
    assign status.in_count_zero = (in_count == '0);
    assign status.div_done      = (div_cnt_reg == DIV_CNT_W'(DIV_ITERS - 1));
    assign status.range_err     = (endpos_reg > END_W'(lim_map_reg)) ||
                                  (span_reg > SPAN_W'(lim_chunk_reg));
    assign status.final_piece   = final_piece;
    assign status.out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(M_TDATA_W - PHYS_W - LEN_W)'(0), out_len_reg, out_phys_reg};
    assign m_axis_tuser  = {out_err_reg, out_wr_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

// ===== sv/block_remap_request_splitter.sv =====
// Logical-to-physical block remap and request splitter.
// Input stream: tuser carries the opcode (load map entry, read, write);
// tdata carries entry index, entry physical block, logical offset, count.
// A load beat writes the map in the accepting cycle and gives no result.
// A read or write beat is split at block boundaries; each piece leaves on
// the output stream with tlast on the final piece, tuser = {error, write}.
// A request past the map or over MAX_CHUNKS blocks gives one error beat;
// a zero count gives one zero-length beat marked last.
// A request passes through the offset-by-block-length divider
// (4 quotient bits per cycle over 40 bits) and the range check, then
// through map read, block multiply and output load for each piece.
// One request is in work at a time.
// The output register holds its beat while m_axis_tready is low; the
// pipeline then waits, and the input takes the next beat once the last
// piece has moved into that register. Reset returns to idle, the block
// length to 16384, and drops any pending beat; map entries are undefined
// until loaded.
module block_remap_request_splitter #(
    parameter int MAP_DEPTH  = 1024,
    parameter int MAX_CHUNKS = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [brrs_pkg::BS_W-1:0]       cfg_wr_data,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // entry_index, entry_physical, logical_offset, byte_count, zero pad
    input  logic [brrs_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [brrs_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // phys_offset, piece_length, zero pad
    output logic [brrs_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // is_write, range_error
    output logic [brrs_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    output logic                            m_axis_tlast
);
    import brrs_pkg::*;

    brrs_cmd_t    cmd;
    brrs_status_t status;

    brrs_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .status        (status)
    );

    brrs_datapath #(
        .MAP_DEPTH  (MAP_DEPTH),
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cmd           (cmd),
        .status        (status)
    );

    a_err_fields_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tlast
                                             && !m_axis_tuser[0])
        else $error("error beat carries nonzero fields");

    a_zero_len_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tuser[1] && m_axis_tdata[64:48] == '0 |-> m_axis_tlast)
        else $error("zero-length beat not marked last");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tdata[64:48] <= BS_MAX)
        else $error("piece length above largest block");

    a_busy_no_take: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step || cmd.rd || cmd.mul |-> !s_axis_tready)
        else $error("input ready while a request is in work");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import brrs_pkg::*;

    localparam int MAP_DEPTH  = 1024;
    localparam int MAX_CHUNKS = 64;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 15;
    localparam int LOADED_SPAN = 64;

    typedef struct packed {
        logic [PHYS_W-1:0] phys;
        logic [LEN_W-1:0]  len;
        logic              is_write;
        logic              last;
        logic              err;
    } piece_t;

    class remap_scoreboard;
        logic [BS_W-1:0]    bsize_reg;
        logic [ENTRY_W-1:0] block_map [MAP_DEPTH];
        bit                 loaded [MAP_DEPTH];
        piece_t             piece_queue [$];
        int                 errors;

        function new();
            bsize_reg = BS_RESET;
            errors = 0;
            foreach (block_map[i]) block_map[i] = '0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        function logic [63:0] block_bytes();
            if (bsize_reg == 0) return 64'd1;
            if (bsize_reg > BS_MAX) return 64'd65536;
            return {47'd0, bsize_reg};
        endfunction

        function int pending();
            return piece_queue.size();
        endfunction

        // true when the request reads only map entries that have been loaded
        function bit safe_req(logic [OFFSET_W-1:0] off, logic [COUNT_W-1:0] cnt);
            logic [63:0] bs, first, lastblk;
            if (cnt == 0) return 1'b1;
            bs = block_bytes();
            first = {24'd0, off} / bs;
            lastblk = ({24'd0, off} + {32'd0, cnt} - 64'd1) / bs;
            if (lastblk >= MAP_DEPTH || lastblk - first + 1 > MAX_CHUNKS) return 1'b1;
            for (int b = int'(first); b <= int'(lastblk); b++)
                if (!loaded[b]) return 1'b0;
            return 1'b1;
        endfunction

        // record a map load, or split one accepted request into the pieces it must produce
        function void note_beat(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                                logic [ENTRY_W-1:0] phys, logic [OFFSET_W-1:0] off,
                                logic [COUNT_W-1:0] cnt);
            logic [63:0] bs, first, lastblk, pos, rem, blk, in_blk, room, len, prod;
            piece_t p;
            int n;
            if (op == OP_LOAD) begin
                block_map[idx] = phys;
                loaded[idx] = 1'b1;
                return;
            end
            if (op != OP_READ && op != OP_WRITE) return;
            p = '0;
            p.is_write = (op == OP_WRITE);
            if (cnt == 0) begin
                p.last = 1'b1;
                piece_queue.push_back(p);
                return;
            end
            bs = block_bytes();
            pos = off;
            first = pos / bs;
            lastblk = (pos + cnt - 1) / bs;
            if (lastblk >= MAP_DEPTH || lastblk - first + 1 > MAX_CHUNKS) begin
                p = '0;
                p.err = 1'b1;
                piece_queue.push_back(p);
                return;
            end
            rem = cnt;
            n = 0;
            while (rem != 0 && n < MAX_CHUNKS) begin
                blk = pos / bs;
                in_blk = pos % bs;
                room = bs - in_blk;
                len = (rem < room) ? rem : room;
                prod = block_map[blk[INDEX_W-1:0]] * bs + in_blk;
                rem = rem - len;
                pos = pos + len;
                p.phys = prod[PHYS_W-1:0];
                p.len = len[LEN_W-1:0];
                p.last = (rem == 0);
                piece_queue.push_back(p);
                n++;
            end
        endfunction

        function void check_beat(logic [M_TDATA_W-1:0] tdata, logic [M_TUSER_W-1:0] tuser,
                                 logic tlast);
            piece_t got, want;
            got.phys = tdata[PHYS_W-1:0];
            got.len = tdata[PHYS_W+LEN_W-1:PHYS_W];
            got.is_write = tuser[0];
            got.err = tuser[1];
            got.last = tlast;
            if (piece_queue.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got %h", $time, got);
                errors++;
                return;
            end
            want = piece_queue.pop_front();
            if (got.phys !== want.phys) begin
                $display("%0t: phys offset expected %h got %h", $time, want.phys, got.phys);
                errors++;
            end
            if (got.len !== want.len) begin
                $display("%0t: piece_length expected %h got %h", $time, want.len, got.len);
                errors++;
            end
            if (got.is_write !== want.is_write) begin
                $display("%0t: is_write expected %b got %b", $time, want.is_write,
                         got.is_write);
                errors++;
            end
            if (got.last !== want.last) begin
                $display("%0t: last_piece expected %b got %b", $time, want.last, got.last);
                errors++;
            end
            if (got.err !== want.err) begin
                $display("%0t: range_error expected %b got %b", $time, want.err, got.err);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [BS_W-1:0]      cfg_wr_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata;
    logic [S_TUSER_W-1:0] s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [M_TUSER_W-1:0] m_axis_tuser;
    logic                 m_axis_tlast;

    remap_scoreboard sb;
    bit steady;

    block_remap_request_splitter #(
        .MAP_DEPTH (MAP_DEPTH),
        .MAX_CHUNKS(MAX_CHUNKS)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("block_remap_request_splitter: mismatch");
        $finish;
    end

    function automatic logic [ENTRY_W-1:0] random_entry();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return $urandom;
    endfunction

    // tdata: entry_index, entry_physical, logical_offset, byte_count, pad
    task automatic send_beat(logic [OPCODE_W-1:0] op, logic [INDEX_W-1:0] idx,
                             logic [ENTRY_W-1:0] phys, logic [OFFSET_W-1:0] off,
                             logic [COUNT_W-1:0] cnt);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 15);
        @(negedge aclk);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata = {6'd0, cnt, off, phys, idx};
        s_axis_tuser = op;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        sb.note_beat(op, idx, phys, off, cnt);
    endtask

    // drop a request that would read a map entry never loaded
    task automatic send_req(logic [OPCODE_W-1:0] op, logic [OFFSET_W-1:0] off,
                            logic [COUNT_W-1:0] cnt);
        if (!sb.safe_req(off, cnt)) return;
        send_beat(op, INDEX_W'($urandom), $urandom, off, cnt);
    endtask

    task automatic wait_idle(int settle);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_block_size(logic [BS_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        sb.bsize_reg = value;
    endtask

    initial begin
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 15);
            @(negedge aclk);
            if (gap != 0) begin
                m_axis_tready = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            sb.check_beat(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
    end

    initial begin
        logic [BS_W-1:0] phase_bs [7];
        logic [63:0] bs, start, endb, tmp;
        int r, nblk, f, counted;
        sb = new();
        steady = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < LOADED_SPAN; i++) begin
            send_beat(OP_LOAD, INDEX_W'(i), random_entry(),
                      OFFSET_W'({$urandom, $urandom}), $urandom);
            send_beat(OP_LOAD, INDEX_W'(MAP_DEPTH - 1 - i), random_entry(),
                      OFFSET_W'({$urandom, $urandom}), $urandom);
        end

        send_beat(OP_LOAD, 10'd1023, '1, '1, '1);
        send_beat(OP_LOAD, 10'd0, '0, '0, '0);
        send_req(OP_READ, OFFSET_W'(0), COUNT_W'(1));
        send_req(OP_WRITE, OFFSET_W'(1023 * 16384), COUNT_W'(16384));
        send_req(OP_READ, OFFSET_W'(1023 * 16384 + 1), COUNT_W'(16384));
        send_req(OP_WRITE, '0, '0);
        send_req(OP_READ, '1, '0);
        send_req(OP_READ, '1, '1);
        send_req(OP_WRITE, OFFSET_W'(16383), COUNT_W'(2));
        send_req(OP_READ, OFFSET_W'(5), COUNT_W'(64 * 16384 - 5));
        send_req(OP_WRITE, OFFSET_W'(5), COUNT_W'(64 * 16384));
        send_beat(OP_UNUSED, '1, '1, OFFSET_W'(16384), COUNT_W'(16384));
        wait_idle(40);
        write_block_size('0);
        send_req(OP_READ, OFFSET_W'(5), COUNT_W'(3));
        send_req(OP_WRITE, OFFSET_W'(1023), COUNT_W'(1));
        send_req(OP_READ, OFFSET_W'(1024), COUNT_W'(1));
        wait_idle(40);
        write_block_size('1);
        send_req(OP_WRITE, OFFSET_W'(65535), COUNT_W'(65538));
        send_req(OP_READ, OFFSET_W'(1023 * 65536), COUNT_W'(65536));
        send_req(OP_READ, 40'h3FF_FFFF, COUNT_W'(1));
        wait_idle(40);

        phase_bs[0] = BS_MIN;
        phase_bs[1] = BS_MAX;
        phase_bs[2] = '0;
        phase_bs[3] = '1;
        phase_bs[4] = BS_W'($urandom_range(2, 100));
        phase_bs[5] = BS_W'($urandom_range(1, 65536));
        phase_bs[6] = BS_RESET;
        for (int ph = 0; ph < 7; ph++) begin
            write_block_size(phase_bs[ph]);
            steady = (ph == 4);
            bs = sb.block_bytes();
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    send_beat(OP_LOAD, INDEX_W'($urandom), random_entry(),
                              OFFSET_W'({$urandom, $urandom}), $urandom);
                end else if (r < 13) begin
                    send_beat(OP_UNUSED, INDEX_W'($urandom), $urandom,
                              OFFSET_W'({$urandom, $urandom}), $urandom);
                    continue;
                end else if (r < 21) begin
                    send_req($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                             OFFSET_W'({$urandom, $urandom}), '0);
                end else if (r < 31) begin
                    send_req($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                             OFFSET_W'({$urandom, $urandom}), $urandom);
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 75) nblk = $urandom_range(1, 4);
                    else if (r < 93) nblk = $urandom_range(5, 16);
                    else if (r < 97) nblk = $urandom_range(17, 63);
                    else if (r < 99) nblk = MAX_CHUNKS;
                    else nblk = MAX_CHUNKS + 1;
                    r = $urandom_range(0, 99);
                    if (r < 10) f = MAP_DEPTH - nblk;
                    else if (r < 15) f = MAP_DEPTH - nblk + 1;
                    else if (nblk >= LOADED_SPAN) f = 0;
                    else f = $urandom_range(0, LOADED_SPAN - nblk);
                    if ($urandom_range(0, 4) == 0) begin
                        start = f * bs;
                        endb = (f + nblk) * bs - 1;
                    end else begin
                        start = f * bs + $urandom_range(0, 32'(bs - 1));
                        endb = (f + nblk - 1) * bs + $urandom_range(0, 32'(bs - 1));
                        if (endb < start) begin
                            tmp = start;
                            start = endb;
                            endb = tmp;
                        end
                    end
                    send_req($urandom_range(0, 1) ? OP_WRITE : OP_READ,
                             start[OFFSET_W-1:0], COUNT_W'(endb - start + 1));
                end
                counted++;
            end
            wait_idle(40);
        end

        steady = 1'b0;
        wait_idle(100);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("block_remap_request_splitter: match");
        else
            $display("block_remap_request_splitter: mismatch");
        $finish;
    end

endmodule

// ===== block_remap_request_splitter.f =====
sv/brrs_pkg.sv
sv/brrs_ctrl.sv
sv/brrs_datapath.sv
sv/block_remap_request_splitter.sv
tb/testbench.sv
